// ===== hw/rtl/ipadl_pkg.sv =====
// ----------------------------------------------------------------------------
// ipadl_pkg
// Shared types, codes and helpers for the allow/deny access level block.
// ----------------------------------------------------------------------------
`default_nettype none

package ipadl_pkg;

    // Access levels, ordered so that a larger code grants more
    localparam logic [2:0] LVL_NONE   = 3'd0;
    localparam logic [2:0] LVL_RDONLY = 3'd1;
    localparam logic [2:0] LVL_RDWR   = 3'd2;
    localparam logic [2:0] LVL_CREAT  = 3'd3;
    localparam logic [2:0] LVL_DROP   = 3'd4;
    localparam logic [2:0] LVL_ALL    = 3'd5;

    // Item actions
    localparam logic [1:0] ACT_RULE  = 2'd0;
    localparam logic [1:0] ACT_ORDER = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // Slot and group fields are 5 and 3 bits wide
    localparam int SLOT_FIELD_SLOTS  = 32;
    localparam int GROUP_FIELD_COUNT = 8;

    // One stored rule
    typedef struct packed {
        logic [31:0] netmask;
        logic [31:0] address;
        logic        deny;
        logic [2:0]  level;
        logic [2:0]  grp;
    } rule_entry_t;

    // Controller state, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic start_query;
        logic wr_rule;
        logic wr_order;
        logic scan_en;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_busy;
    } status_t;

    function automatic logic [2:0] deny_map(input logic [2:0] lvl);
        logic [2:0] res;
        case (lvl)
            LVL_ALL:    res = LVL_NONE;
            LVL_DROP:   res = LVL_CREAT;
            LVL_CREAT:  res = LVL_RDWR;
            LVL_RDWR:   res = LVL_RDONLY;
            LVL_RDONLY: res = LVL_NONE;
            default:    res = LVL_CREAT;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ipadl_ram.sv =====
// ----------------------------------------------------------------------------
// ipadl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ipadl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ipadl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipadl_ctrl
// Sequencer: decodes input transfers, runs the rule scan, hands off results.
// ----------------------------------------------------------------------------
`default_nettype none

module ipadl_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         action,
    input  wire ipadl_pkg::status_t status,
    output ipadl_pkg::cmd_t         cmd
);

    ipadl_pkg::state_t state_reg;
    ipadl_pkg::state_t state_next;

    logic accept;

    assign in_ready = (state_reg == ipadl_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next       = state_reg;
        cmd              = '0;
        case (state_reg)
            ipadl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ipadl_pkg::ACT_RULE:  cmd.wr_rule = 1'b1;
                        ipadl_pkg::ACT_ORDER: cmd.wr_order = 1'b1;
                        ipadl_pkg::ACT_QUERY:
                        begin
                            cmd.start_query = 1'b1;
                            state_next      = ipadl_pkg::ST_SCAN;
                        end
                        default: ;  // unused action, dropped
                    endcase
                end
            end
            ipadl_pkg::ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ipadl_pkg::ST_DRAIN;
                end
            end
            ipadl_pkg::ST_DRAIN:
            begin
                // last read data is folded in this cycle
                state_next = ipadl_pkg::ST_FINISH;
            end
            ipadl_pkg::ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ipadl_pkg::ST_IDLE;
                end
            end
            default: state_next = ipadl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ipadl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ipadl_dp.sv =====
// ----------------------------------------------------------------------------
// ipadl_dp
// Datapath: rule RAM, valid and order bits, per-group accumulators,
// group combine and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipadl_dp #(
    parameter int RULE_SLOTS  = 32,
    parameter int GROUP_COUNT = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ipadl_pkg::cmd_t cmd,
    output ipadl_pkg::status_t   status,
    input  wire logic [4:0]      entry_slot,
    input  wire logic [2:0]      group_id,
    input  wire logic            is_deny,
    input  wire logic [2:0]      rule_level,
    input  wire logic [31:0]     rule_address,
    input  wire logic [31:0]     rule_netmask,
    input  wire logic            entry_enable,
    input  wire logic            deny_first,
    input  wire logic [31:0]     query_address,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic      [2:0]      granted_level
);

    // Only slots and groups reachable through the 5/3-bit fields exist
    localparam int SLOTS_USED  = (RULE_SLOTS < ipadl_pkg::SLOT_FIELD_SLOTS) ?
                                 RULE_SLOTS : ipadl_pkg::SLOT_FIELD_SLOTS;
    localparam int GROUPS_USED = (GROUP_COUNT < ipadl_pkg::GROUP_FIELD_COUNT) ?
                                 GROUP_COUNT : ipadl_pkg::GROUP_FIELD_COUNT;
    localparam int IW = (SLOTS_USED > 1) ? $clog2(SLOTS_USED) : 1;
    localparam int GW = (GROUPS_USED > 1) ? $clog2(GROUPS_USED) : 1;
    localparam logic [5:0] SLOT_LIMIT  = 6'(SLOTS_USED);
    localparam logic [3:0] GROUP_LIMIT = 4'(GROUPS_USED);
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS_USED - 1);

    logic [IW-1:0]   scan_cnt_reg;
    logic            pend_reg;
    logic [IW-1:0]   pend_idx_reg;
    logic [31:0]     qaddr_reg;
    logic [SLOTS_USED-1:0]  valid_reg;
    logic [GROUPS_USED-1:0] order_reg;
    logic [GROUPS_USED-1:0] a_hit_reg;
    logic [GROUPS_USED-1:0] d_hit_reg;
    logic [2:0]      a_max_reg [GROUPS_USED];
    logic [2:0]      d_max_reg [GROUPS_USED];
    logic            out_valid_reg;
    logic [2:0]      out_level_reg;

    ipadl_pkg::rule_entry_t wr_entry;
    ipadl_pkg::rule_entry_t rd_entry;
    logic            slot_ok;
    logic            wr_grp_ok;
    logic            rule_we;
    logic [2:0]      lvl_sat;
    logic            rd_grp_ok;
    logic [GW-1:0]   rd_gidx;
    logic            hit;
    logic [2:0]      answer;

    assign slot_ok   = {1'b0, entry_slot} < SLOT_LIMIT;
    assign wr_grp_ok = {1'b0, group_id} < GROUP_LIMIT;
    assign rule_we   = cmd.wr_rule && slot_ok;
    assign lvl_sat   = (rule_level > ipadl_pkg::LVL_ALL) ? ipadl_pkg::LVL_ALL : rule_level;

    always_comb
    begin
        wr_entry.netmask = rule_netmask;
        wr_entry.address = rule_address;
        wr_entry.deny    = is_deny;
        wr_entry.level   = lvl_sat;
        wr_entry.grp     = group_id;
    end

    ipadl_ram #(
        .WIDTH ($bits(ipadl_pkg::rule_entry_t)),
        .DEPTH (SLOTS_USED),
        .AW    (IW)
    ) u_rule_ram (
        .clk   (clk),
        .we    (rule_we),
        .waddr (entry_slot[IW-1:0]),
        .wdata (wr_entry),
        .re    (cmd.scan_en),
        .raddr (scan_cnt_reg),
        .rdata (rd_entry)
    );

    assign rd_grp_ok = {1'b0, rd_entry.grp} < GROUP_LIMIT;
    assign rd_gidx   = rd_entry.grp[GW-1:0];
    assign hit = pend_reg && valid_reg[pend_idx_reg] && rd_grp_ok &&
                 ((qaddr_reg & rd_entry.netmask) == rd_entry.address);

    assign status.scan_last = (scan_cnt_reg == LAST_SLOT);
    assign status.out_busy  = out_valid_reg && !out_ready;

    // Scan sequencing and query address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
        end
        else
        begin
            if (cmd.start_query)
            begin
                scan_cnt_reg <= '0;
            end
            else if (cmd.scan_en)
            begin
                scan_cnt_reg <= scan_cnt_reg + IW'(1);
            end
            pend_reg     <= cmd.scan_en;
            pend_idx_reg <= scan_cnt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            qaddr_reg <= query_address;
        end
    end

    // Slot valid bits and group order bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            order_reg <= '0;
        end
        else
        begin
            if (rule_we)
            begin
                valid_reg[entry_slot[IW-1:0]] <= entry_enable;
            end
            if (cmd.wr_order && wr_grp_ok)
            begin
                order_reg[group_id[GW-1:0]] <= deny_first;
            end
        end
    end

    // Per-group accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_hit_reg <= '0;
            d_hit_reg <= '0;
            for (int g = 0; g < GROUPS_USED; g++)
            begin
                a_max_reg[g] <= ipadl_pkg::LVL_NONE;
                d_max_reg[g] <= ipadl_pkg::LVL_NONE;
            end
        end
        else if (cmd.start_query)
        begin
            a_hit_reg <= '0;
            d_hit_reg <= '0;
            for (int g = 0; g < GROUPS_USED; g++)
            begin
                a_max_reg[g] <= ipadl_pkg::LVL_NONE;
                d_max_reg[g] <= ipadl_pkg::LVL_NONE;
            end
        end
        else if (hit)
        begin
            if (rd_entry.deny)
            begin
                if (!d_hit_reg[rd_gidx] || (rd_entry.level > d_max_reg[rd_gidx]))
                begin
                    d_max_reg[rd_gidx] <= rd_entry.level;
                end
                d_hit_reg[rd_gidx] <= 1'b1;
            end
            else
            begin
                if (!a_hit_reg[rd_gidx] || (rd_entry.level > a_max_reg[rd_gidx]))
                begin
                    a_max_reg[rd_gidx] <= rd_entry.level;
                end
                a_hit_reg[rd_gidx] <= 1'b1;
            end
        end
    end

    // Group combine: at most eight narrow steps
    always_comb
    begin
        logic [2:0] a_lvl;
        logic [2:0] d_lvl;
        logic [2:0] r_lvl;
        answer = ipadl_pkg::LVL_NONE;
        for (int g = 0; g < GROUPS_USED; g++)
        begin
            a_lvl = (a_max_reg[g] == ipadl_pkg::LVL_ALL) ? ipadl_pkg::LVL_DROP : a_max_reg[g];
            d_lvl = ipadl_pkg::deny_map(d_max_reg[g]);
            if (a_hit_reg[g] && d_hit_reg[g])
            begin
                if (order_reg[g])
                begin
                    r_lvl = (a_lvl > d_lvl) ? a_lvl : d_lvl;
                end
                else
                begin
                    r_lvl = (a_lvl < d_lvl) ? a_lvl : d_lvl;
                end
            end
            else if (a_hit_reg[g])
            begin
                r_lvl = a_lvl;
            end
            else if (d_hit_reg[g])
            begin
                r_lvl = d_lvl;
            end
            else
            begin
                r_lvl = ipadl_pkg::LVL_NONE;
            end
            if (r_lvl > answer)
            begin
                answer = r_lvl;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_level_reg <= answer;
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted_level = out_level_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ip_allow_deny_access_level_core.sv =====
// ----------------------------------------------------------------------------
// ip_allow_deny_access_level_core
// Allow/deny rule table with per-group ordering; answers access-level queries.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | sink      | in_valid / in_ready  | action, entry_slot, group_id,
//          |           |                      | is_deny, rule_level, rule_address,
//          |           |                      | rule_netmask, entry_enable,
//          |           |                      | deny_first, query_address
//  out     | source    | out_valid/out_ready  | granted_level
//
//  Rule and order writes complete in the cycle of their transfer; in_ready stays
//  high. A query reads min(RULE_SLOTS, 32) rule slots from the rule RAM, one per
//  cycle, then folds in the last read data and does the group combine before the
//  result is loaded into the output register; in_ready is low meanwhile.
//  The output register lets writes and the next query proceed while a result
//  waits; a query finishing with a result still stalled waits in its last cycle.
//  Reset clears slot valid bits, group order bits and all control state; rule
//  RAM contents are not cleared (an invalid slot never takes part).
//  Action code 3 is dropped; writes to a slot beyond the table, and order writes
//  to a group beyond it, are dropped; a rule with such a group never matches.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_allow_deny_access_level_core #(
    parameter int RULE_SLOTS  = 32,
    parameter int GROUP_COUNT = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [4:0]  entry_slot,
    input  wire logic [2:0]  group_id,
    input  wire logic        is_deny,
    input  wire logic [2:0]  rule_level,
    input  wire logic [31:0] rule_address,
    input  wire logic [31:0] rule_netmask,
    input  wire logic        entry_enable,
    input  wire logic        deny_first,
    input  wire logic [31:0] query_address,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [2:0]  granted_level
);

    ipadl_pkg::cmd_t    cmd;
    ipadl_pkg::status_t status;

    // Sequencer
    ipadl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    // Rule storage, matching and combine
    ipadl_dp #(
        .RULE_SLOTS  (RULE_SLOTS),
        .GROUP_COUNT (GROUP_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .entry_slot    (entry_slot),
        .group_id      (group_id),
        .is_deny       (is_deny),
        .rule_level    (rule_level),
        .rule_address  (rule_address),
        .rule_netmask  (rule_netmask),
        .entry_enable  (entry_enable),
        .deny_first    (deny_first),
        .query_address (query_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .granted_level (granted_level)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ipadl_chk.sv =====
// ----------------------------------------------------------------------------
// ipadl_chk
// Port-level checks for the access level core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ipadl_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [1:0] action,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] granted_level
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(granted_level))
        else $error("stalled result changed");

    // Granted level never reaches all
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> granted_level <= ipadl_pkg::LVL_DROP)
        else $error("granted level out of range");

    // A query occupies the block for its scan
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == ipadl_pkg::ACT_QUERY |=> !in_ready)
        else $error("input taken during scan");

    // Writes finish in their own cycle
    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action != ipadl_pkg::ACT_QUERY |=> in_ready)
        else $error("write stalled the input");

endmodule

bind ip_allow_deny_access_level_core ipadl_chk u_ipadl_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .granted_level (granted_level)
);

`default_nettype wire

// ===== tb/tb_ip_allow_deny_access_level_core.sv =====
// ----------------------------------------------------------------------------
// tb_ip_allow_deny_access_level_core
// Self-checking bench for the allow/deny access level block. A queue-fed driver
// sends rule writes, group order writes, queries and dropped actions in random
// bursts. Each transfer updates a local rule table, and every query predicts
// the granted level. A monitor takes results under a stalling out_ready and
// checks each one against the oldest predicted level.
// ----------------------------------------------------------------------------
module tb_ip_allow_deny_access_level_core;

    localparam int          SLOTS        = 32;
    localparam int          GROUPS       = 8;
    localparam logic [1:0]  ACT_UNUSED   = 2'd3;   // dropped by the block
    localparam int          RESULT_WAIT  = 40;     // wait for the last query result
    localparam int          IDLE_LIMIT   = 3000;   // cycles with no transfer at all
    localparam int          HOLD_CYCLES  = 400;    // long receiver hold-off
    localparam int          HOLD_AFTER   = 120;    // results taken before the hold

    // One input transfer, field for field as on the ports
    typedef struct {
        logic [1:0]  action;
        logic [4:0]  entry_slot;
        logic [2:0]  group_id;
        logic        is_deny;
        logic [2:0]  rule_level;
        logic [31:0] rule_address;
        logic [31:0] rule_netmask;
        logic        entry_enable;
        logic        deny_first;
        logic [31:0] query_address;
    } acl_item_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [1:0]  action        = '0;
    logic [4:0]  entry_slot    = '0;
    logic [2:0]  group_id      = '0;
    logic        is_deny       = 1'b0;
    logic [2:0]  rule_level    = '0;
    logic [31:0] rule_address  = '0;
    logic [31:0] rule_netmask  = '0;
    logic        entry_enable  = 1'b0;
    logic        deny_first    = 1'b0;
    logic [31:0] query_address = '0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [2:0]  granted_level;

    // Local copy of the rule table and group order bits
    logic [31:0] tbl_addr  [SLOTS];
    logic [31:0] tbl_mask  [SLOTS];
    logic        tbl_valid [SLOTS];
    logic        tbl_deny  [SLOTS];
    logic [2:0]  tbl_level [SLOTS];
    logic [2:0]  tbl_group [SLOTS];
    logic        grp_deny_first [GROUPS];

    acl_item_t   pending_items[$];
    logic [2:0]  expected_grants[$];
    logic [31:0] addr_pool[8];

    int          err_count;
    int          n_rule, n_order, n_query, n_dropped;
    int          grant_hist[8];
    int          idle_cycles;

    // sender burst state
    int          burst_left;
    int          gap_left;
    acl_item_t   next_item;
    acl_item_t   taken_item;

    // receiver stall state
    int          hold_left;
    logic        hold_done;
    int          seg_left;
    int          seg_mode;
    int          rcv_tick;
    int          rcv_taken;

    ip_allow_deny_access_level_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .entry_slot    (entry_slot),
        .group_id      (group_id),
        .is_deny       (is_deny),
        .rule_level    (rule_level),
        .rule_address  (rule_address),
        .rule_netmask  (rule_netmask),
        .entry_enable  (entry_enable),
        .deny_first    (deny_first),
        .query_address (query_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .granted_level (granted_level)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Level prediction
    // ------------------------------------------------------------------------

    // Deny side mapping: a deny of a level below all leaves the level just below it;
    // a deny of all leaves none, and a deny of none still grants creat.
    function automatic logic [2:0] deny_grant(input logic [2:0] lvl);
        logic [2:0] res;
        case (lvl)
            ipadl_pkg::LVL_ALL:    res = ipadl_pkg::LVL_NONE;
            ipadl_pkg::LVL_DROP:   res = ipadl_pkg::LVL_CREAT;
            ipadl_pkg::LVL_CREAT:  res = ipadl_pkg::LVL_RDWR;
            ipadl_pkg::LVL_RDWR:   res = ipadl_pkg::LVL_RDONLY;
            ipadl_pkg::LVL_RDONLY: res = ipadl_pkg::LVL_NONE;
            default:               res = ipadl_pkg::LVL_CREAT;
        endcase
        return res;
    endfunction

    function automatic logic [2:0] predict_grant(input logic [31:0] addr);
        logic       allow_hit [GROUPS];
        logic       deny_hit  [GROUPS];
        logic [2:0] allow_top [GROUPS];
        logic [2:0] deny_top  [GROUPS];
        logic [2:0] a_lvl;
        logic [2:0] d_lvl;
        logic [2:0] g_lvl;
        logic [2:0] best;
        int         i;
        int         g;
        best = ipadl_pkg::LVL_NONE;
        for (g = 0; g < GROUPS; g++)
        begin
            allow_hit[g] = 1'b0;
            deny_hit[g]  = 1'b0;
            allow_top[g] = ipadl_pkg::LVL_NONE;
            deny_top[g]  = ipadl_pkg::LVL_NONE;
        end
        // highest matching level per group and side
        for (i = 0; i < SLOTS; i++)
        begin
            if (tbl_valid[i] && ((addr & tbl_mask[i]) == tbl_addr[i]))
            begin
                g = int'(tbl_group[i]);
                if (tbl_deny[i])
                begin
                    if (!deny_hit[g] || tbl_level[i] > deny_top[g])
                        deny_top[g] = tbl_level[i];
                    deny_hit[g] = 1'b1;
                end
                else
                begin
                    if (!allow_hit[g] || tbl_level[i] > allow_top[g])
                        allow_top[g] = tbl_level[i];
                    allow_hit[g] = 1'b1;
                end
            end
        end
        // combine sides per group, then take the best group
        for (g = 0; g < GROUPS; g++)
        begin
            if (allow_hit[g] || deny_hit[g])
            begin
                a_lvl = (allow_top[g] == ipadl_pkg::LVL_ALL) ?
                        ipadl_pkg::LVL_DROP : allow_top[g];
                d_lvl = deny_grant(deny_top[g]);
                if (!allow_hit[g])
                    g_lvl = d_lvl;
                else if (!deny_hit[g])
                    g_lvl = a_lvl;
                else if (grp_deny_first[g])
                    g_lvl = (a_lvl > d_lvl) ? a_lvl : d_lvl;
                else
                    g_lvl = (a_lvl < d_lvl) ? a_lvl : d_lvl;
                if (g_lvl > best)
                    best = g_lvl;
            end
        end
        return best;
    endfunction

    // Apply one accepted transfer to the local table, queue a level for a query
    task automatic note_transfer(input acl_item_t it);
        logic [2:0] lvl;
        logic [2:0] grant;
        case (it.action)
            ipadl_pkg::ACT_RULE:
            begin
                lvl = (it.rule_level > ipadl_pkg::LVL_ALL) ?
                      ipadl_pkg::LVL_ALL : it.rule_level;
                tbl_addr[it.entry_slot]  = it.rule_address;
                tbl_mask[it.entry_slot]  = it.rule_netmask;
                tbl_valid[it.entry_slot] = it.entry_enable;
                tbl_deny[it.entry_slot]  = it.is_deny;
                tbl_level[it.entry_slot] = lvl;
                tbl_group[it.entry_slot] = it.group_id;
                n_rule++;
            end
            ipadl_pkg::ACT_ORDER:
            begin
                grp_deny_first[it.group_id] = it.deny_first;
                n_order++;
            end
            ipadl_pkg::ACT_QUERY:
            begin
                grant = predict_grant(it.query_address);
                expected_grants.push_back(grant);
                grant_hist[grant]++;
                n_query++;
            end
            default:
                n_dropped++;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [2:0] got,
                                   input logic [2:0] want);
        $display("MISMATCH %s: granted_level %0d, predicted %0d", what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // Item builders; fields an action does not use are random
    // ------------------------------------------------------------------------

    function automatic acl_item_t rand_fill();
        acl_item_t it;
        it.action        = 2'($urandom);
        it.entry_slot    = 5'($urandom);
        it.group_id      = 3'($urandom);
        it.is_deny       = 1'($urandom);
        it.rule_level    = 3'($urandom);
        it.rule_address  = $urandom;
        it.rule_netmask  = $urandom;
        it.entry_enable  = 1'($urandom);
        it.deny_first    = 1'($urandom);
        it.query_address = $urandom;
        return it;
    endfunction

    function automatic acl_item_t make_rule(input logic [4:0] slot, input logic [2:0] grp,
                                            input logic deny, input logic [2:0] lvl,
                                            input logic [31:0] addr, input logic [31:0] mask,
                                            input logic en);
        acl_item_t it;
        it              = rand_fill();
        it.action       = ipadl_pkg::ACT_RULE;
        it.entry_slot   = slot;
        it.group_id     = grp;
        it.is_deny      = deny;
        it.rule_level   = lvl;
        it.rule_address = addr;
        it.rule_netmask = mask;
        it.entry_enable = en;
        return it;
    endfunction

    function automatic acl_item_t make_order(input logic [2:0] grp, input logic df);
        acl_item_t it;
        it            = rand_fill();
        it.action     = ipadl_pkg::ACT_ORDER;
        it.group_id   = grp;
        it.deny_first = df;
        return it;
    endfunction

    function automatic acl_item_t make_query(input logic [31:0] addr);
        acl_item_t it;
        it               = rand_fill();
        it.action        = ipadl_pkg::ACT_QUERY;
        it.query_address = addr;
        return it;
    endfunction

    function automatic acl_item_t make_dropped();
        acl_item_t it;
        it        = rand_fill();
        it.action = ACT_UNUSED;
        return it;
    endfunction

    function automatic logic [31:0] prefix_mask(input int len);
        return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    endfunction

    // Prefix lengths used by random rules and queries; /0 kept rare
    function automatic int pick_prefix();
        int lens[12] = '{0, 1, 8, 8, 12, 16, 16, 20, 24, 24, 28, 32};
        return lens[$urandom_range(0, 11)];
    endfunction

    function automatic acl_item_t rand_rule();
        acl_item_t   it;
        logic [31:0] m;
        int          pick;
        it   = rand_fill();
        m    = prefix_mask(pick_prefix());
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            // noise: arbitrary address and mask
            it = make_rule(it.entry_slot, it.group_id, it.is_deny, it.rule_level,
                           $urandom, $urandom, it.entry_enable);
        end
        else if (pick == 1)
        begin
            // address bits outside the mask: rule can only match with a full mask
            it = make_rule(it.entry_slot, it.group_id, it.is_deny, it.rule_level,
                           (addr_pool[$urandom_range(0, 7)] & m) | ($urandom & ~m),
                           m, it.entry_enable);
        end
        else
        begin
            it = make_rule(it.entry_slot, it.group_id, it.is_deny, it.rule_level,
                           addr_pool[$urandom_range(0, 7)] & m, m,
                           $urandom_range(0, 9) != 0);
        end
        return it;
    endfunction

    function automatic acl_item_t rand_query();
        logic [31:0] base;
        base = addr_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 9) == 0)
            return make_query($urandom);
        // perturb only bits below a random prefix so that rules tend to hit
        return make_query(base ^ ($urandom & ~prefix_mask(pick_prefix())));
    endfunction

    // ------------------------------------------------------------------------
    // Driver: bursts of transfers with random gaps, fed from pending_items
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            action        <= '0;
            entry_slot    <= '0;
            group_id      <= '0;
            is_deny       <= 1'b0;
            rule_level    <= '0;
            rule_address  <= '0;
            rule_netmask  <= '0;
            entry_enable  <= 1'b0;
            deny_first    <= 1'b0;
            query_address <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else
        begin
            // transfer on the input: update the local table from the ports
            if (in_valid && in_ready)
            begin
                taken_item.action        = action;
                taken_item.entry_slot    = entry_slot;
                taken_item.group_id      = group_id;
                taken_item.is_deny       = is_deny;
                taken_item.rule_level    = rule_level;
                taken_item.rule_address  = rule_address;
                taken_item.rule_netmask  = rule_netmask;
                taken_item.entry_enable  = entry_enable;
                taken_item.deny_first    = deny_first;
                taken_item.query_address = query_address;
                note_transfer(taken_item);
            end
            // payload may change only once the current one is gone
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_items.size() != 0)
                begin
                    next_item = pending_items.pop_front();
                    in_valid      <= 1'b1;
                    action        <= next_item.action;
                    entry_slot    <= next_item.entry_slot;
                    group_id      <= next_item.group_id;
                    is_deny       <= next_item.is_deny;
                    rule_level    <= next_item.rule_level;
                    rule_address  <= next_item.rule_address;
                    rule_netmask  <= next_item.rule_netmask;
                    entry_enable  <= next_item.entry_enable;
                    deny_first    <= next_item.deny_first;
                    query_address <= next_item.query_address;
                    if (burst_left <= 1)
                    begin
                        // new burst; some gaps are zero so long runs occur too,
                        // some are long enough to span a whole query
                        burst_left <= $urandom_range(1, 24);
                        case ($urandom_range(0, 9))
                            0, 1, 2:       gap_left <= 0;
                            3, 4, 5, 6, 7: gap_left <= $urandom_range(1, 6);
                            default:       gap_left <= $urandom_range(10, 45);
                        endcase
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: segments of different stall patterns, plus one long hold-off
    // while the sender keeps offering, so the output register and the query
    // engine both fill and in_ready drops.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
            seg_left  <= 0;
            seg_mode  <= 0;
            rcv_tick  <= 0;
            rcv_taken <= 0;
        end
        else
        begin
            rcv_tick <= rcv_tick + 1;
            if (out_valid && out_ready)
                rcv_taken <= rcv_taken + 1;
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && rcv_taken >= HOLD_AFTER)
            begin
                out_ready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_mode <= $urandom_range(0, 3);
                    seg_left <= $urandom_range(16, 120);
                end
                else
                begin
                    seg_left <= seg_left - 1;
                end
                case (seg_mode)
                    0:       out_ready <= 1'b1;                       // no stalls
                    1:       out_ready <= 1'($urandom);               // coin flip
                    2:       out_ready <= (rcv_tick % 5 == 0);        // one in five
                    default: out_ready <= ($urandom_range(0, 7) == 0); // mostly stalled
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: each output transfer against the oldest predicted level
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_grants.size() == 0)
                report_mismatch("result with no query pending", granted_level, 3'bx);
            else if (granted_level !== expected_grants[0])
                report_mismatch("granted_level", granted_level,
                                expected_grants.pop_front());
            else
                void'(expected_grants.pop_front());
        end
    end

    // Watchdog: a run of cycles with no transfer on either side ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TIMEOUT after %0d cycles without a transfer", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Wait until every item has gone in and every predicted level has come out
    task automatic wait_drained();
        @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_grants.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int i;
        int p;
        int n;
        int query_pct;
        int order_pct;
        int roll;

        err_count   = 0;
        n_rule      = 0;
        n_order     = 0;
        n_query     = 0;
        n_dropped   = 0;
        idle_cycles = 0;
        for (i = 0; i < 8; i++)
            grant_hist[i] = 0;
        // reset state of the local table: all slots invalid, all groups allow first
        for (i = 0; i < SLOTS; i++)
        begin
            tbl_addr[i]  = '0;
            tbl_mask[i]  = '0;
            tbl_valid[i] = 1'b0;
            tbl_deny[i]  = 1'b0;
            tbl_level[i] = ipadl_pkg::LVL_NONE;
            tbl_group[i] = '0;
        end
        for (i = 0; i < GROUPS; i++)
            grp_deny_first[i] = 1'b0;
        for (i = 0; i < 8; i++)
            addr_pool[i] = $urandom;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Rule RAM is not cleared by reset: write every slot (disabled) before
        // the first query so no scan reads a never-written entry.
        for (i = 0; i < SLOTS; i++)
            pending_items.push_back(make_rule(5'(i), 3'($urandom), 1'($urandom),
                                              3'($urandom), $urandom, $urandom, 1'b0));

        // Directed part
        // empty table answers none
        pending_items.push_back(make_query(32'h0A01_0203));
        // allow all is lowered to drop
        pending_items.push_back(make_rule(5'd0, 3'd0, 1'b0, ipadl_pkg::LVL_ALL,
                                          32'h0A00_0000, 32'hFF00_0000, 1'b1));
        pending_items.push_back(make_query(32'h0A01_0203));
        // deny with an out-of-range level saturates to all; allow first takes min
        pending_items.push_back(make_rule(5'd1, 3'd0, 1'b1, 3'd7,
                                          32'h0A00_0000, 32'hFF00_0000, 1'b1));
        pending_items.push_back(make_query(32'h0A01_0203));
        // deny first takes the max
        pending_items.push_back(make_order(3'd0, 1'b1));
        pending_items.push_back(make_query(32'h0A01_0203));
        // deny of none matching everything grants creat
        pending_items.push_back(make_rule(5'd2, 3'd1, 1'b1, ipadl_pkg::LVL_NONE,
                                          32'h0, 32'h0, 1'b1));
        pending_items.push_back(make_query(32'h0B00_0000));
        // address with bits outside its mask never matches
        pending_items.push_back(make_rule(5'd3, 3'd2, 1'b0, ipadl_pkg::LVL_CREAT,
                                          32'hC0A8_0001, 32'hFFFF_FF00, 1'b1));
        pending_items.push_back(make_query(32'hC0A8_0001));
        // disabled write leaves the slot out of every query
        pending_items.push_back(make_rule(5'd4, 3'd3, 1'b0, ipadl_pkg::LVL_DROP,
                                          32'h0, 32'h0, 1'b0));
        // unused action code is dropped
        pending_items.push_back(make_dropped());
        // top slot, top group, level 6 saturates, full mask
        pending_items.push_back(make_rule(5'd31, 3'd7, 1'b0, 3'd6,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        pending_items.push_back(make_order(3'd7, 1'b1));
        pending_items.push_back(make_query(32'hFFFF_FFFF));
        pending_items.push_back(make_rule(5'd5, 3'd7, 1'b1, ipadl_pkg::LVL_RDWR,
                                          32'hF000_0000, 32'hF000_0000, 1'b1));
        pending_items.push_back(make_query(32'hFFFF_FFFF));
        pending_items.push_back(make_order(3'd7, 1'b0));
        pending_items.push_back(make_query(32'hFFFF_FFFF));
        // overwrite slot 2 disabled, then single-address allow rdonly
        pending_items.push_back(make_rule(5'd2, 3'd1, 1'b1, ipadl_pkg::LVL_NONE,
                                          32'h0, 32'h0, 1'b0));
        pending_items.push_back(make_rule(5'd6, 3'd4, 1'b0, ipadl_pkg::LVL_RDONLY,
                                          32'h0, 32'hFFFF_FFFF, 1'b1));
        pending_items.push_back(make_query(32'h0000_0000));
        // deny rdonly against allow rdwr in an allow-first group
        pending_items.push_back(make_rule(5'd7, 3'd5, 1'b1, ipadl_pkg::LVL_RDONLY,
                                          32'h0, 32'h0, 1'b1));
        pending_items.push_back(make_rule(5'd8, 3'd5, 1'b0, ipadl_pkg::LVL_RDWR,
                                          32'h0, 32'h0, 1'b1));
        pending_items.push_back(make_query(32'h1234_5678));
        // sender pauses here until every predicted level has come back
        wait_drained();

        // Random part: four phases with different action mixes
        for (p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin query_pct = 45; order_pct = 8;  end
                1:       begin query_pct = 70; order_pct = 5;  end
                2:       begin query_pct = 25; order_pct = 15; end
                default: begin query_pct = 50; order_pct = 10; end
            endcase
            for (n = 0; n < 325; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    pending_items.push_back(make_dropped());
                else if (roll < 2 + order_pct)
                    pending_items.push_back(make_order(3'($urandom), 1'($urandom)));
                else if (roll < 2 + order_pct + query_pct)
                    pending_items.push_back(rand_query());
                else
                    pending_items.push_back(rand_rule());
            end
            wait_drained();
        end

        // let any stray output show up before the verdict
        repeat (RESULT_WAIT) @(negedge clk);
        while (expected_grants.size() != 0)
            report_mismatch("predicted level never came out", 3'bx,
                            expected_grants.pop_front());

        $display("Covered %0d rule writes, %0d order writes, %0d queries, %0d dropped actions",
                 n_rule, n_order, n_query, n_dropped);
        $display("Answers none/rdonly/rdwr/creat/drop: %0d/%0d/%0d/%0d/%0d, %0d mismatches",
                 grant_hist[0], grant_hist[1], grant_hist[2], grant_hist[3],
                 grant_hist[4], err_count);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
